FILE: hw/rtl/tgausd_pkg.sv
// Shared types, codes and header constants for the TGA stream decoder.
package tgausd_pkg;

  // Header layout (byte offsets within the 18-byte header)
  localparam logic [4:0] POS_TYPE      = 5'd2;
  localparam logic [4:0] POS_WIDTH_LO  = 5'd12;
  localparam logic [4:0] POS_WIDTH_HI  = 5'd13;
  localparam logic [4:0] POS_HEIGHT_LO = 5'd14;
  localparam logic [4:0] POS_HEIGHT_HI = 5'd15;
  localparam logic [4:0] POS_DEPTH     = 5'd16;
  localparam logic [4:0] POS_DESC      = 5'd17;

  // Accepted formats
  localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
  localparam logic [7:0] TYPE_GRAY      = 8'd3;
  localparam logic [7:0] DEPTH_GRAY     = 8'd8;
  localparam logic [7:0] DEPTH_RGB      = 8'd24;
  localparam logic [7:0] DEPTH_RGBA     = 8'd32;

  // Byte index within a true-color pixel (file order is B, G, R, A)
  localparam logic [1:0] BYTE_BLUE  = 2'd0;
  localparam logic [1:0] BYTE_GREEN = 2'd1;
  localparam logic [1:0] BYTE_RED   = 2'd2;

  typedef enum logic [1:0] {
    KIND_HDR_OK    = 2'd0,
    KIND_PIXEL     = 2'd1,
    KIND_REJECT    = 2'd2,
    KIND_EARLY_END = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXELS = 2'd1,
    PH_IGNORE = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [14:0] image_width;
    logic [14:0] image_height;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] column;
    logic [14:0] row;
    logic        is_gray;
    logic        last_pixel;
  } result_t;

endpackage

FILE: hw/rtl/tgausd_stream_if.sv
// Valid/ready channel interfaces for file bytes in and decoded results out.
interface tgausd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface tgausd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [14:0] image_width;
  logic [14:0] image_height;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [14:0] column;
  logic [14:0] row;
  logic        is_gray;
  logic        last_pixel;

  modport source (output valid, output kind, output image_width, output image_height,
                  output red, output green, output blue, output column, output row,
                  output is_gray, output last_pixel, input ready);
  modport sink   (input valid, input kind, input image_width, input image_height,
                  input red, input green, input blue, input column, input row,
                  input is_gray, input last_pixel, output ready);
endinterface

FILE: hw/rtl/tgausd_parser.sv
// Header parser and pixel assembler: one file byte per transfer, at most one result.
module tgausd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          data_byte,
  input  logic                eos,
  output logic                res_valid,
  output tgausd_pkg::result_t res
);

  tgausd_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  depth_r, depth_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [7:0]  blue_r, blue_nxt;
  logic [7:0]  green_r, green_nxt;
  logic [7:0]  red_r, red_nxt;
  logic [14:0] col_r, col_nxt;
  logic [14:0] row_r, row_nxt;

  logic [14:0] w_eff, h_eff;
  logic [15:0] col_inc, row_inc;
  logic        hdr_end, fmt_ok, size_zero, is_gray, px_done, last_px, col_wrap;

  // Effective size: a set top bit means zero
  assign w_eff     = width_r[15]  ? 15'd0 : width_r[14:0];
  assign h_eff     = height_r[15] ? 15'd0 : height_r[14:0];
  assign size_zero = (w_eff == 15'd0) || (h_eff == 15'd0);
  assign hdr_end   = (pos_r == tgausd_pkg::POS_DESC);
  assign is_gray   = (type_r == tgausd_pkg::TYPE_GRAY);

  // Descriptor byte arrives on the last header byte; low nibble 0 or 8, bits 2:1 clear
  always_comb begin
    fmt_ok = 1'b0;
    if (data_byte[2:0] == 3'd0) begin
      if (type_r == tgausd_pkg::TYPE_TRUECOLOR) begin
        fmt_ok = (depth_r == tgausd_pkg::DEPTH_RGB) || (depth_r == tgausd_pkg::DEPTH_RGBA);
      end else if (type_r == tgausd_pkg::TYPE_GRAY) begin
        fmt_ok = (depth_r == tgausd_pkg::DEPTH_GRAY);
      end
    end
  end

  // Pixel completion and position bookkeeping
  assign px_done  = is_gray || (bip_r == 2'd3) ||
                    ((bip_r == tgausd_pkg::BYTE_RED) && (depth_r != tgausd_pkg::DEPTH_RGBA));
  assign col_inc  = {1'b0, col_r} + 16'd1;
  assign row_inc  = {1'b0, row_r} + 16'd1;
  assign col_wrap = (col_inc >= {1'b0, w_eff});
  assign last_px  = (col_inc == {1'b0, w_eff}) && (row_inc == {1'b0, h_eff});

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      tgausd_pkg::PH_HEADER: begin
        if (hdr_end) begin
          phase_nxt = (!fmt_ok || size_zero) ? tgausd_pkg::PH_IGNORE : tgausd_pkg::PH_PIXELS;
        end
      end
      tgausd_pkg::PH_PIXELS: begin
        if (px_done && last_px) begin
          phase_nxt = tgausd_pkg::PH_IGNORE;
        end
      end
      default: phase_nxt = phase_r;
    endcase
    if (eos) begin
      phase_nxt = tgausd_pkg::PH_HEADER;
    end
  end

  // Result for this byte
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    case (phase_r)
      tgausd_pkg::PH_HEADER: begin
        if (hdr_end) begin
          res_valid = 1'b1;
          if (!fmt_ok) begin
            res.kind = tgausd_pkg::KIND_REJECT;
          end else if (eos && !size_zero) begin
            res.kind = tgausd_pkg::KIND_EARLY_END;
          end else begin
            res.kind         = tgausd_pkg::KIND_HDR_OK;
            res.image_width  = w_eff;
            res.image_height = h_eff;
            res.is_gray      = is_gray;
          end
        end else if (eos) begin
          res_valid = 1'b1;
          res.kind  = tgausd_pkg::KIND_EARLY_END;
        end
      end
      tgausd_pkg::PH_PIXELS: begin
        if (px_done) begin
          res_valid = 1'b1;
          if (eos && !last_px) begin
            res.kind = tgausd_pkg::KIND_EARLY_END;
          end else begin
            res.kind       = tgausd_pkg::KIND_PIXEL;
            res.red        = (is_gray || (bip_r == tgausd_pkg::BYTE_RED)) ? data_byte : red_r;
            res.green      = is_gray ? data_byte : green_r;
            res.blue       = is_gray ? data_byte : blue_r;
            res.column     = col_r;
            res.row        = row_r;
            res.is_gray    = is_gray;
            res.last_pixel = last_px;
          end
        end else if (eos) begin
          res_valid = 1'b1;
          res.kind  = tgausd_pkg::KIND_EARLY_END;
        end
      end
      default: res_valid = 1'b0;
    endcase
    res_valid = res_valid && in_fire;
  end

  // Header fields, byte gathering and pixel position
  always_comb begin
    pos_nxt    = pos_r;
    type_nxt   = type_r;
    depth_nxt  = depth_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    bip_nxt    = bip_r;
    blue_nxt   = blue_r;
    green_nxt  = green_r;
    red_nxt    = red_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    case (phase_r)
      tgausd_pkg::PH_HEADER: begin
        case (pos_r)
          tgausd_pkg::POS_TYPE:      type_nxt          = data_byte;
          tgausd_pkg::POS_WIDTH_LO:  width_nxt[7:0]    = data_byte;
          tgausd_pkg::POS_WIDTH_HI:  width_nxt[15:8]   = data_byte;
          tgausd_pkg::POS_HEIGHT_LO: height_nxt[7:0]   = data_byte;
          tgausd_pkg::POS_HEIGHT_HI: height_nxt[15:8]  = data_byte;
          tgausd_pkg::POS_DEPTH:     depth_nxt         = data_byte;
          default:                   pos_nxt           = pos_r;
        endcase
        if (hdr_end) begin
          pos_nxt = 5'd0;
          bip_nxt = 2'd0;
          col_nxt = 15'd0;
          row_nxt = 15'd0;
        end else begin
          pos_nxt = pos_r + 5'd1;
        end
      end
      tgausd_pkg::PH_PIXELS: begin
        if (is_gray) begin
          blue_nxt  = data_byte;
          green_nxt = data_byte;
          red_nxt   = data_byte;
        end else begin
          case (bip_r)
            tgausd_pkg::BYTE_BLUE:  blue_nxt  = data_byte;
            tgausd_pkg::BYTE_GREEN: green_nxt = data_byte;
            tgausd_pkg::BYTE_RED:   red_nxt   = data_byte;
            default:                red_nxt   = red_r;
          endcase
        end
        if (px_done) begin
          bip_nxt = 2'd0;
          if (col_wrap) begin
            col_nxt = 15'd0;
            row_nxt = row_inc[14:0];
          end else begin
            col_nxt = col_inc[14:0];
          end
        end else begin
          bip_nxt = bip_r + 2'd1;
        end
      end
      default: pos_nxt = pos_r;
    endcase
    // Restart the parse after the last byte of a file
    if (eos) begin
      pos_nxt    = 5'd0;
      type_nxt   = 8'd0;
      depth_nxt  = 8'd0;
      width_nxt  = 16'd0;
      height_nxt = 16'd0;
      bip_nxt    = 2'd0;
      col_nxt    = 15'd0;
      row_nxt    = 15'd0;
    end
  end

  // Advance state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= tgausd_pkg::PH_HEADER;
      pos_r    <= 5'd0;
      type_r   <= 8'd0;
      depth_r  <= 8'd0;
      width_r  <= 16'd0;
      height_r <= 16'd0;
      bip_r    <= 2'd0;
      col_r    <= 15'd0;
      row_r    <= 15'd0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      type_r   <= type_nxt;
      depth_r  <= depth_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      bip_r    <= bip_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  // Hold gathered channel bytes
  always_ff @(posedge clk) begin
    if (in_fire) begin
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
      red_r   <= red_nxt;
    end
  end

  a_pos_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == tgausd_pkg::PH_PIXELS) |-> ((col_r < w_eff) && (row_r < h_eff)))
    else $error("pixel position outside image");

  a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && eos) |=> ((phase_r == tgausd_pkg::PH_HEADER) && (pos_r == 5'd0)))
    else $error("parser did not restart after end of stream");

  a_pixel_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.kind == tgausd_pkg::KIND_PIXEL)) |-> (phase_r == tgausd_pkg::PH_PIXELS))
    else $error("pixel result outside pixel phase");

endmodule

FILE: hw/rtl/tgausd_out_buf.sv
// Two-entry result queue that decouples the parser from the result channel.
module tgausd_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tgausd_pkg::result_t push_item,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output tgausd_pkg::result_t head_item
);

  tgausd_pkg::result_t ent_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = ent_r[rd_r];

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |-> !push)
    else $error("push into a full result queue");

endmodule

FILE: hw/rtl/tga_uncompressed_stream_decoder.sv
// Top level of the streaming uncompressed TGA decoder.
//
//   channel  dir  payload                                         transfer
//   in_ch    in   data_byte, end_of_stream                        valid & ready
//   out_ch   out  kind, image_width/height, red/green/blue,       valid & ready
//                 column, row, is_gray, last_pixel
//
// One file byte is taken per cycle while the queue is not full; a result is ready in
// the output queue in the cycle after its byte. The rate is set by the single parser stage.
// Reset (rst_n low, synchronous) returns the parser to the header and empties the queue.
// in_ch.ready drops only while two results wait in the output queue.
module tga_uncompressed_stream_decoder (
  input  logic         clk,
  input  logic         rst_n,
  tgausd_in_if.sink    in_ch,
  tgausd_out_if.source out_ch
);

  tgausd_pkg::result_t res, head;
  logic                res_valid, in_fire, buf_full, head_valid, pop;

  assign in_ch.ready = !buf_full;
  assign in_fire     = in_ch.valid && !buf_full;
  assign pop         = head_valid && out_ch.ready;

  tgausd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .data_byte (in_ch.data_byte),
    .eos       (in_ch.end_of_stream),
    .res_valid (res_valid),
    .res       (res)
  );

  tgausd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_item  (res),
    .pop        (pop),
    .full       (buf_full),
    .head_valid (head_valid),
    .head_item  (head)
  );

  // Drive the result channel from the queue head
  assign out_ch.valid        = head_valid;
  assign out_ch.kind         = head.kind;
  assign out_ch.image_width  = head.image_width;
  assign out_ch.image_height = head.image_height;
  assign out_ch.red          = head.red;
  assign out_ch.green        = head.green;
  assign out_ch.blue         = head.blue;
  assign out_ch.column       = head.column;
  assign out_ch.row          = head.row;
  assign out_ch.is_gray      = head.is_gray;
  assign out_ch.last_pixel   = head.last_pixel;

endmodule

FILE: dv/tb.sv
// Testbench for the streaming uncompressed TGA decoder: byte stimulus, predictor, result check.
`timescale 1ns / 100ps

module tb;

  localparam int NO_EOS = -1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tgausd_in_if  in_ch ();
  tgausd_out_if out_ch ();

  tga_uncompressed_stream_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned mismatch_count = 0;
  int unsigned headers_seen = 0;
  int unsigned pixels_seen = 0;
  int unsigned rejects_seen = 0;
  int unsigned early_ends_seen = 0;

  tgausd_pkg::result_t decoded_results [$];

  // Parser state mirrored by the predictor
  tgausd_pkg::phase_t parse_state;
  logic [4:0]  hdr_pos;
  logic [7:0]  img_type;
  logic [7:0]  px_depth;
  logic [7:0]  desc_bits;
  logic [15:0] width_raw;
  logic [15:0] height_raw;
  logic [1:0]  byte_idx;
  logic [7:0]  red_acc;
  logic [7:0]  green_acc;
  logic [7:0]  blue_acc;
  logic [14:0] col_pos;
  logic [14:0] row_pos;

  function automatic logic [14:0] eff_size(input logic [15:0] raw);
    return raw[15] ? 15'd0 : raw[14:0];
  endfunction

  task automatic restart_parser();
    parse_state = tgausd_pkg::PH_HEADER;
    hdr_pos     = '0;
    img_type    = '0;
    px_depth    = '0;
    desc_bits   = '0;
    width_raw   = '0;
    height_raw  = '0;
    byte_idx    = '0;
    red_acc     = '0;
    green_acc   = '0;
    blue_acc    = '0;
    col_pos     = '0;
    row_pos     = '0;
  endtask

  // Advance the parser by one file byte and queue the result it causes, if any
  task automatic decode_byte(input logic [7:0] b, input logic eos);
    tgausd_pkg::result_t r;
    logic [14:0] w;
    logic [14:0] h;
    logic        gray;
    logic        fmt_ok;
    logic        emit;
    logic        done;
    logic        last;
    int          bpp;
    r    = '0;
    emit = 1'b0;
    w    = eff_size(width_raw);
    h    = eff_size(height_raw);
    gray = (img_type == tgausd_pkg::TYPE_GRAY);
    case (parse_state)
      tgausd_pkg::PH_HEADER: begin
        case (hdr_pos)
          tgausd_pkg::POS_TYPE:      img_type = b;
          tgausd_pkg::POS_WIDTH_LO:  width_raw[7:0] = b;
          tgausd_pkg::POS_WIDTH_HI:  width_raw[15:8] = b;
          tgausd_pkg::POS_HEIGHT_LO: height_raw[7:0] = b;
          tgausd_pkg::POS_HEIGHT_HI: height_raw[15:8] = b;
          tgausd_pkg::POS_DEPTH:     px_depth = b;
          tgausd_pkg::POS_DESC:      desc_bits = b;
          default: ;
        endcase
        if (hdr_pos < tgausd_pkg::POS_DESC) begin
          hdr_pos = hdr_pos + 5'd1;
          if (eos) begin
            emit   = 1'b1;
            r.kind = tgausd_pkg::KIND_EARLY_END;
          end
        end else begin
          gray    = (img_type == tgausd_pkg::TYPE_GRAY);
          w       = eff_size(width_raw);
          h       = eff_size(height_raw);
          hdr_pos = '0;
          emit    = 1'b1;
          fmt_ok  = (desc_bits[3:0] == 4'h0 || desc_bits[3:0] == 4'h8)
                    && desc_bits[2:1] == 2'b00
                    && ((img_type == tgausd_pkg::TYPE_TRUECOLOR
                         && (px_depth == tgausd_pkg::DEPTH_RGB
                             || px_depth == tgausd_pkg::DEPTH_RGBA))
                        || (img_type == tgausd_pkg::TYPE_GRAY
                            && px_depth == tgausd_pkg::DEPTH_GRAY));
          if (!fmt_ok) begin
            parse_state = tgausd_pkg::PH_IGNORE;
            r.kind      = tgausd_pkg::KIND_REJECT;
          end else begin
            parse_state = (w == 0 || h == 0) ? tgausd_pkg::PH_IGNORE : tgausd_pkg::PH_PIXELS;
            col_pos     = '0;
            row_pos     = '0;
            byte_idx    = '0;
            if (eos && parse_state == tgausd_pkg::PH_PIXELS) begin
              r.kind = tgausd_pkg::KIND_EARLY_END;
            end else begin
              r.kind         = tgausd_pkg::KIND_HDR_OK;
              r.image_width  = w;
              r.image_height = h;
              r.is_gray      = gray;
            end
          end
        end
      end
      tgausd_pkg::PH_PIXELS: begin
        bpp  = gray ? 1 : (px_depth == tgausd_pkg::DEPTH_RGBA ? 4 : 3);
        done = 1'b0;
        if (bpp == 1) begin
          red_acc   = b;
          green_acc = b;
          blue_acc  = b;
          done      = 1'b1;
        end else begin
          case (byte_idx)
            tgausd_pkg::BYTE_BLUE:  blue_acc = b;
            tgausd_pkg::BYTE_GREEN: green_acc = b;
            tgausd_pkg::BYTE_RED: begin
              red_acc = b;
              done    = (bpp == 3);
            end
            default:    done = 1'b1;  // alpha byte, dropped
          endcase
        end
        if (done) begin
          last     = (col_pos + 1 == w) && (row_pos + 1 == h);
          byte_idx = '0;
          emit     = 1'b1;
          if (eos && !last) begin
            r.kind = tgausd_pkg::KIND_EARLY_END;
          end else begin
            r.kind       = tgausd_pkg::KIND_PIXEL;
            r.red        = red_acc;
            r.green      = green_acc;
            r.blue       = blue_acc;
            r.column     = col_pos;
            r.row        = row_pos;
            r.is_gray    = gray;
            r.last_pixel = last;
          end
          col_pos = col_pos + 15'd1;
          if (col_pos >= w) begin
            col_pos = '0;
            row_pos = row_pos + 15'd1;
          end
          if (last) parse_state = tgausd_pkg::PH_IGNORE;
        end else begin
          byte_idx = byte_idx + 2'd1;
          if (eos) begin
            emit   = 1'b1;
            r.kind = tgausd_pkg::KIND_EARLY_END;
          end
        end
      end
      default: ;
    endcase
    if (emit) decoded_results.push_back(r);
    if (eos) restart_parser();
  endtask

  // Send one file byte; called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_stream <= eos;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b, eos);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send the 18 header bytes, filler random; stop after the byte that carries end of stream
  task automatic send_header(input logic [7:0] typ, input logic [15:0] w_raw,
                             input logic [15:0] h_raw, input logic [7:0] depth,
                             input logic [7:0] desc, input int eos_at);
    logic [7:0] hdr [0:17];
    for (int i = 0; i < 18; i++) hdr[i] = 8'($urandom_range(255));
    hdr[tgausd_pkg::POS_TYPE]      = typ;
    hdr[tgausd_pkg::POS_WIDTH_LO]  = w_raw[7:0];
    hdr[tgausd_pkg::POS_WIDTH_HI]  = w_raw[15:8];
    hdr[tgausd_pkg::POS_HEIGHT_LO] = h_raw[7:0];
    hdr[tgausd_pkg::POS_HEIGHT_HI] = h_raw[15:8];
    hdr[tgausd_pkg::POS_DEPTH]     = depth;
    hdr[tgausd_pkg::POS_DESC]      = desc;
    for (int i = 0; i < 18; i++) begin
      send_byte(hdr[i], i == eos_at);
      if (i == eos_at) break;
    end
  endtask

  task automatic send_body(input int n, input int eos_at);
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom_range(255)), i == eos_at);
      if (i == eos_at) break;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40)
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Drive the result channel ready
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    tgausd_pkg::result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      if (decoded_results.size() == 0) begin
        report_mismatch("result with nothing expected, kind", out_ch.kind, 0);
      end else begin
        want = decoded_results.pop_front();
        case (want.kind)
          tgausd_pkg::KIND_HDR_OK: headers_seen++;
          tgausd_pkg::KIND_PIXEL:  pixels_seen++;
          tgausd_pkg::KIND_REJECT: rejects_seen++;
          default:                 early_ends_seen++;
        endcase
        if (out_ch.kind !== want.kind) report_mismatch("kind", out_ch.kind, want.kind);
        if (out_ch.image_width !== want.image_width)
          report_mismatch("image_width", out_ch.image_width, want.image_width);
        if (out_ch.image_height !== want.image_height)
          report_mismatch("image_height", out_ch.image_height, want.image_height);
        if (out_ch.red !== want.red) report_mismatch("red", out_ch.red, want.red);
        if (out_ch.green !== want.green) report_mismatch("green", out_ch.green, want.green);
        if (out_ch.blue !== want.blue) report_mismatch("blue", out_ch.blue, want.blue);
        if (out_ch.column !== want.column) report_mismatch("column", out_ch.column, want.column);
        if (out_ch.row !== want.row) report_mismatch("row", out_ch.row, want.row);
        if (out_ch.is_gray !== want.is_gray)
          report_mismatch("is_gray", out_ch.is_gray, want.is_gray);
        if (out_ch.last_pixel !== want.last_pixel)
          report_mismatch("last_pixel", out_ch.last_pixel, want.last_pixel);
      end
    end
  end

  // 24- and 32-bit true color, final pixel on end of stream, trailing bytes after the image
  task automatic test_truecolor();
    send_header(tgausd_pkg::TYPE_TRUECOLOR, 16'd2, 16'd2, tgausd_pkg::DEPTH_RGB, 8'h00,
                NO_EOS);
    send_body(12, 11);
    send_header(tgausd_pkg::TYPE_TRUECOLOR, 16'd3, 16'd1, tgausd_pkg::DEPTH_RGBA, 8'h28,
                NO_EOS);
    send_body(15, 14);
  endtask

  // Grayscale with the byte extremes and all upper descriptor bits set
  task automatic test_grayscale();
    send_header(tgausd_pkg::TYPE_GRAY, 16'd2, 16'd2, tgausd_pkg::DEPTH_GRAY, 8'h08, NO_EOS);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'ha5, 1'b1);
    send_header(tgausd_pkg::TYPE_GRAY, 16'd1, 16'd1, tgausd_pkg::DEPTH_GRAY, 8'hf8, NO_EOS);
    send_byte(8'h80, 1'b1);
  endtask

  // Unsupported type, depth or descriptor; trailing bytes ignored until end of stream
  task automatic test_rejected_formats();
    logic [7:0] bad_fmt [0:7][0:2];
    bad_fmt = '{'{8'd1, 8'd8, 8'h00},
                '{tgausd_pkg::TYPE_TRUECOLOR, 8'd16, 8'h00},
                '{tgausd_pkg::TYPE_GRAY, tgausd_pkg::DEPTH_RGB, 8'h00},
                '{tgausd_pkg::TYPE_TRUECOLOR, tgausd_pkg::DEPTH_RGB, 8'h01},
                '{tgausd_pkg::TYPE_TRUECOLOR, tgausd_pkg::DEPTH_RGBA, 8'h0f},
                '{8'd10, tgausd_pkg::DEPTH_RGB, 8'h00},
                '{8'h00, 8'h00, 8'h00},
                '{8'hff, 8'hff, 8'hff}};
    for (int i = 0; i < 8; i++) begin
      send_header(bad_fmt[i][0], 16'd2, 16'd2, bad_fmt[i][1], bad_fmt[i][2], NO_EOS);
      send_body(3, 2);
    end
    // rejection on the last header byte together with end of stream
    send_header(tgausd_pkg::TYPE_GRAY, 16'd1, 16'd1, tgausd_pkg::DEPTH_RGBA, 8'h00, 17);
  endtask

  // Negative, zero and largest sizes
  task automatic test_size_extremes();
    send_header(tgausd_pkg::TYPE_TRUECOLOR, 16'h8000, 16'd1, tgausd_pkg::DEPTH_RGB, 8'h00,
                NO_EOS);
    send_body(4, 3);
    send_header(tgausd_pkg::TYPE_GRAY, 16'd1, 16'hffff, tgausd_pkg::DEPTH_GRAY, 8'h00,
                NO_EOS);
    send_body(2, 1);
    send_header(tgausd_pkg::TYPE_TRUECOLOR, 16'd0, 16'd5, tgausd_pkg::DEPTH_RGBA, 8'h08, 17);
    send_header(tgausd_pkg::TYPE_TRUECOLOR, 16'h7fff, 16'h7fff, tgausd_pkg::DEPTH_RGB, 8'h00,
                NO_EOS);
    send_body(10, 9);
    // end of stream on the byte that completes a pixel that is not the last
    send_header(tgausd_pkg::TYPE_GRAY, 16'h7fff, 16'd1, tgausd_pkg::DEPTH_GRAY, 8'h00,
                NO_EOS);
    send_body(6, 5);
  endtask

  // End of stream inside the header, on its last byte, and inside a pixel
  task automatic test_early_end();
    send_header(tgausd_pkg::TYPE_TRUECOLOR, 16'd2, 16'd2, tgausd_pkg::DEPTH_RGB, 8'h00, 0);
    send_header(tgausd_pkg::TYPE_TRUECOLOR, 16'd2, 16'd2, tgausd_pkg::DEPTH_RGB, 8'h00, 9);
    send_header(tgausd_pkg::TYPE_TRUECOLOR, 16'd2, 16'd2, tgausd_pkg::DEPTH_RGB, 8'h00, 17);
    send_header(tgausd_pkg::TYPE_TRUECOLOR, 16'd2, 16'd1, tgausd_pkg::DEPTH_RGBA, 8'h00,
                NO_EOS);
    send_body(2, 1);
    send_header(tgausd_pkg::TYPE_TRUECOLOR, 16'd2, 16'd1, tgausd_pkg::DEPTH_RGBA, 8'h00,
                NO_EOS);
    send_body(4, 3);
  endtask

  // One random file: mostly well formed with random content, some noise headers
  task automatic random_file();
    int          pick;
    int          shape;
    int          bpp;
    int          body;
    int          total;
    int          eos_pos;
    logic [7:0]  typ;
    logic [7:0]  depth;
    logic [7:0]  desc;
    logic [15:0] w_raw;
    logic [15:0] h_raw;
    pick  = $urandom_range(99);
    w_raw = 16'($urandom_range(1, 4));
    h_raw = 16'($urandom_range(1, 4));
    if (pick < 80) begin
      case ($urandom_range(2))
        0: begin
          typ = tgausd_pkg::TYPE_TRUECOLOR; depth = tgausd_pkg::DEPTH_RGB;  bpp = 3;
        end
        1: begin
          typ = tgausd_pkg::TYPE_TRUECOLOR; depth = tgausd_pkg::DEPTH_RGBA; bpp = 4;
        end
        default: begin
          typ = tgausd_pkg::TYPE_GRAY; depth = tgausd_pkg::DEPTH_GRAY; bpp = 1;
        end
      endcase
      desc  = 8'($urandom_range(15) * 16 + $urandom_range(1) * 8);
      shape = $urandom_range(19);
      case (shape)
        0: w_raw = 16'h8000 | 16'($urandom_range(16'h7fff));
        1: w_raw = 16'd0;
        2: h_raw = 16'h8000 | 16'($urandom_range(16'h7fff));
        3: w_raw = 16'h7fff;
        default: ;
      endcase
      body = eff_size(w_raw) * eff_size(h_raw) * bpp;
      if (body > 64) body = $urandom_range(1, 20);
    end else begin
      case ($urandom_range(2))
        0: typ = tgausd_pkg::TYPE_TRUECOLOR;
        1: typ = tgausd_pkg::TYPE_GRAY;
        default: typ = 8'($urandom_range(255));
      endcase
      case ($urandom_range(3))
        0: depth = tgausd_pkg::DEPTH_GRAY;
        1: depth = tgausd_pkg::DEPTH_RGB;
        2: depth = tgausd_pkg::DEPTH_RGBA;
        default: depth = 8'($urandom_range(255));
      endcase
      desc = 8'($urandom_range(255));
      body = $urandom_range(12);
    end
    total   = body + $urandom_range(3);
    eos_pos = ($urandom_range(99) < 12) ? $urandom_range(17 + total) : 17 + total;
    send_header(typ, w_raw, h_raw, depth, desc, eos_pos);
    if (eos_pos >= 18) send_body(total, eos_pos - 18);
  endtask

  task automatic test_random_files(input int unsigned n_bytes);
    int unsigned stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) random_file();
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = 8'h00;
    in_ch.end_of_stream = 1'b0;
    restart_parser();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 22;
    recv_idle_pct = 63;
    test_truecolor();
    test_grayscale();
    test_rejected_formats();
    test_size_extremes();
    test_early_end();
    test_random_files(315);

    send_idle_pct = 63;
    recv_idle_pct = 22;
    test_random_files(315);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_files(315);

    in_ch.valid <= 1'b0;
    while (decoded_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d file bytes: %0d headers accepted, %0d pixels, %0d rejects,",
             bytes_sent, headers_seen, pixels_seen, rejects_seen);
    $display("%0d early ends, under sender and receiver stalls and at full rate.",
             early_ends_seen);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop if the stream hangs
  initial begin
    #5000000;
    $display("Timeout with %0d results outstanding", decoded_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
